/* src/frame_bitmap_allocator_defines.svh */
// ---------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define FBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define FBA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* src/fba_pkg.sv */
// ---------------------------------------------------------------------------
// fba_pkg
// Types, constants and helper functions of the frame bitmap allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = MAX_FRAMES / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORD_COUNT);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int FRAME_W    = WORD_AW + BIT_AW;
  localparam int FCOUNT_W   = 13;
  localparam int GROUPS     = WORD_COUNT / WORD_BITS;
  localparam int GROUP_AW   = $clog2(GROUPS);
  localparam int CFG_AW     = 2;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(MAX_FRAMES);
  localparam logic [CFG_AW-1:0]   REG_FRAME_COUNT = '0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_SKIP    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_WB
  } fsm_t;

  // Priority encode result: lowest set bit of a word
  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] idx;
  } ffs_t;

  function automatic ffs_t find_first_set(input logic [WORD_BITS-1:0] v);
    ffs_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_AW'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/fba_ram.sv */
// ---------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/frame_bitmap_allocator.sv */
// ---------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a one-bit-per-frame bitmap in RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on in_* and are taken at a clock edge with start high and
//   busy low. Each request yields exactly one result on out_*, shown for one
//   cycle with out_valid high; the receiver cannot stall it.
//   Allocate with an empty entry: a summary vector of full words is scanned
//   in four groups into registers, the lowest eligible word is picked and
//   read from the bitmap RAM, then the word is priority encoded and written
//   back. The result is registered at the end of write-back, and a new
//   request is taken only once the allocator is idle again. With no eligible
//   word the result is set from the pick step and no write-back runs.
//   Free and test read one bitmap word through the registered RAM port and
//   answer from the write-back step, after which a new request is taken.
//   Skipped requests (allocate with entry set, free of an empty entry, unused
//   opcode) answer in the cycle right after acceptance with no busy time.
//   frame_count is to be written over the APB port while idle, which the
//   block does not enforce; only whole 32-frame words below it are searched.
//   Reset (rst_n low, synchronous) clears the per-word valid and full bits,
//   so every frame reads free at once; no clearing pass runs over the RAM.
// ---------------------------------------------------------------------------
`default_nettype none
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [fba_pkg::FRAME_W-1:0]   in_entry_frame,
  input  wire logic [fba_pkg::FRAME_W-1:0]   in_query_frame,
  input  wire logic                          in_kernel_page,
  input  wire logic                          in_writable,
  // result channel
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [fba_pkg::FRAME_W-1:0]        out_new_frame,
  output logic                               out_present_bit,
  output logic                               out_rw_bit,
  output logic                               out_user_bit,
  output logic                               out_bit_is_set,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fba_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import fba_pkg::*;

  // ---- state ----
  fsm_t                   state_r, state_nxt;
  logic [FCOUNT_W-1:0]    frame_count_r;
  logic [WORD_COUNT-1:0]  vld_r;
  logic [WORD_COUNT-1:0]  full_r;

  // latched request
  op_t                    op_r;
  logic [FRAME_W-1:0]     entry_r;
  logic [FRAME_W-1:0]     query_r;
  logic                   kernel_r;
  logic                   wr_r;
  logic [WORD_AW-1:0]     word_idx_r, word_idx_nxt;

  // scan results per group
  ffs_t                   grp_r [GROUPS];
  ffs_t                   grp_nxt [GROUPS];
  logic [WORD_COUNT-1:0]  eligible;
  logic [WORD_AW:0]       words_lim;

  logic                   pick_found;
  logic [WORD_AW-1:0]     pick_word;

  // RAM
  logic                   ram_we;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [WORD_AW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;
  logic [WORD_BITS-1:0]   word;
  ffs_t                   zero_pos;

  // outputs
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]     out_frame_r, out_frame_nxt;
  logic                   out_p_r, out_p_nxt;
  logic                   out_rw_r, out_rw_nxt;
  logic                   out_u_r, out_u_nxt;
  logic                   out_bit_r, out_bit_nxt;

  logic                   accept;
  logic                   cfg_wr;
  op_t                    in_op;
  logic                   in_alloc_go;
  logic                   in_needs_read;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_op  = op_t'(in_opcode);

  assign in_alloc_go   = (in_op == OP_ALLOC) && (in_entry_frame == '0);
  assign in_needs_read = ((in_op == OP_FREE) && (in_entry_frame != '0)) || (in_op == OP_TEST);

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_FRAME_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FCOUNT_RESET;
    end else if (cfg_wr) begin
      frame_count_r <= pwdata[FCOUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FRAME_COUNT) begin
      prdata = {{(32-FCOUNT_W){1'b0}}, frame_count_r};
    end
  end

  // ---- eligible words: not full and below the configured limit ----
  assign words_lim = frame_count_r[FCOUNT_W-1] ? (WORD_AW+1)'(WORD_COUNT)
                                               : {1'b0, frame_count_r[FCOUNT_W-2:BIT_AW]};

  always_comb begin
    for (int w = 0; w < WORD_COUNT; w++) begin
      eligible[w] = !full_r[w] && ((WORD_AW+1)'(w) < words_lim);
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = find_first_set(eligible[g*WORD_BITS +: WORD_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // lowest group with a free word
  always_comb begin
    pick_found = 1'b0;
    pick_word  = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_r[g].found) begin
        pick_found = 1'b1;
        pick_word  = {GROUP_AW'(g), grp_r[g].idx};
      end
    end
  end

  // ---- bitmap RAM ----
  assign ram_raddr = (state_r == S_PICK) ? pick_word
                   : ((in_op == OP_TEST) ? in_query_frame[FRAME_W-1:BIT_AW]
                                         : in_entry_frame[FRAME_W-1:BIT_AW]);

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written words read as all free
  assign word     = vld_r[word_idx_r] ? ram_rdata : '0;
  assign zero_pos = find_first_set(~word);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_alloc_go) begin
          state_nxt = S_SCAN;
        end else if (accept && in_needs_read) begin
          state_nxt = S_WB;
        end
      end
      S_SCAN: state_nxt = S_PICK;
      S_PICK: state_nxt = pick_found ? S_WB : S_IDLE;
      S_WB:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- outputs and bitmap update ----
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = STS_SKIP;
    out_frame_nxt  = '0;
    out_p_nxt      = 1'b0;
    out_rw_nxt     = 1'b0;
    out_u_nxt      = 1'b0;
    out_bit_nxt    = 1'b0;
    ram_we         = 1'b0;
    ram_wdata      = word;
    word_idx_nxt   = word_idx_r;
    unique case (state_r)
      S_IDLE: begin
        word_idx_nxt = ram_raddr;
        if (accept && !in_alloc_go && !in_needs_read) begin
          // skipped request answers at once
          out_valid_nxt = 1'b1;
          if (in_op == OP_ALLOC) begin
            out_frame_nxt = in_entry_frame;
          end
        end
      end
      S_SCAN: begin
      end
      S_PICK: begin
        word_idx_nxt = pick_word;
        if (!pick_found) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NO_FREE;
        end
      end
      S_WB: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STS_DONE;
        if (op_r == OP_ALLOC) begin
          ram_we        = 1'b1;
          ram_wdata     = word | (WORD_BITS'(1) << zero_pos.idx);
          out_frame_nxt = {word_idx_r, zero_pos.idx};
          out_p_nxt     = 1'b1;
          out_rw_nxt    = wr_r;
          out_u_nxt     = !kernel_r;
        end else if (op_r == OP_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = word & ~(WORD_BITS'(1) << entry_r[BIT_AW-1:0]);
        end else begin
          out_frame_nxt = entry_r;
          out_bit_nxt   = word[query_r[BIT_AW-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      full_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[word_idx_r]  <= 1'b1;
        full_r[word_idx_r] <= &ram_wdata;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    word_idx_r <= word_idx_nxt;
    if (accept) begin
      op_r     <= in_op;
      entry_r  <= in_entry_frame;
      query_r  <= in_query_frame;
      kernel_r <= in_kernel_page;
      wr_r     <= in_writable;
    end
    if (out_valid_nxt) begin
      out_status_r <= out_status_nxt;
      out_frame_r  <= out_frame_nxt;
      out_p_r      <= out_p_nxt;
      out_rw_r     <= out_rw_nxt;
      out_u_r      <= out_u_nxt;
      out_bit_r    <= out_bit_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_new_frame   = out_frame_r;
  assign out_present_bit = out_p_r;
  assign out_rw_bit      = out_rw_r;
  assign out_user_bit    = out_u_r;
  assign out_bit_is_set  = out_bit_r;

  // ---- assertions ----
  `FBA_ASSERT(a_wb_returns_idle, (state_r == S_WB) |=> (state_r == S_IDLE), "write-back did not end the request")
  `FBA_NEVER(a_write_outside_wb, ram_we && (state_r != S_WB), "bitmap written outside write-back")
  `FBA_ASSERT(a_req_held, (state_r != S_IDLE) |=> $stable(op_r), "request changed while busy")
  `FBA_NEVER(a_pick_full_word, (state_r == S_PICK) && pick_found && full_r[pick_word], "picked a full word")
  `FBA_NEVER(a_free_sets_bit, ram_we && (op_r == OP_FREE) && ((ram_wdata & ~word) != '0), "free set a bitmap bit")

endmodule

`default_nettype wire
